FILE: src/mrlbq_pkg.sv
package mrlbq_pkg;

    // Number of in-order request slots.
    localparam int QUEUE_DEPTH = 16;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int LAT_W     = 16;
    localparam int HDR_W     = 8;
    localparam int BW_W      = 8;
    localparam int MIF_W     = 5;
    localparam int WC_W      = 12;
    localparam int WORDS_W   = 13;
    localparam int OUT_CNT_W = 5;

    // Configuration register indexes; register i sits at byte address 4 * i.
    typedef enum logic [1:0] {
        REG_TOTAL_LATENCY   = 2'd0,
        REG_HEADER_WORDS    = 2'd1,
        REG_BANDWIDTH_WORDS = 2'd2,
        REG_MAX_IN_FLIGHT   = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic            req_type;
        logic [WC_W-1:0] payload_words;
    } t_req;

    typedef struct packed {
        logic                 accepted;
        logic                 rejected_full;
        logic [OUT_CNT_W-1:0] completed_count;
        logic [OUT_CNT_W-1:0] free_slots;
    } t_rsp;

    typedef struct packed {
        logic [LAT_W-1:0] total_latency;
        logic [HDR_W-1:0] header_words;
        logic [BW_W-1:0]  bandwidth_words;
        logic [MIF_W-1:0] max_in_flight;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic item_is_req;
        logic walk_stop;
    } t_dp_sts;

endpackage

FILE: src/mrlbq_ctrl.sv
module mrlbq_ctrl
    import mrlbq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_stall,
    output logic    o_rsp_valid,
    input  logic    i_rsp_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   accept;
    logic   emit;

    assign accept      = (r_state == ST_IDLE) && i_req_valid;
    assign emit        = (r_state == ST_FINISH) && (!r_rsp_valid || !i_rsp_stall);
    assign o_req_stall = (r_state != ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == ST_EXEC);
    assign o_cmd.walk = (r_state == ST_WALK);
    assign o_cmd.emit = emit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = i_sts.item_is_req ? ST_FINISH : ST_WALK;
            end
            ST_WALK: begin
                if (i_sts.walk_stop) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        priority if (emit) begin
            n_rsp_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

FILE: src/mrlbq_dp.sv
module mrlbq_dp
    import mrlbq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_rsp    o_rsp
);

    localparam int LIM_W = (CNT_W > MIF_W) ? CNT_W : MIF_W;

    typedef enum logic [1:0] {
        PH_EMPTY = 2'd0,
        PH_WAIT  = 2'd1,
        PH_XFER  = 2'd2
    } t_phase;

    t_phase             r_phase [QUEUE_DEPTH];
    logic [LAT_W-1:0]   r_lat   [QUEUE_DEPTH];
    logic [WORDS_W-1:0] r_words [QUEUE_DEPTH];
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_occ;
    logic [BW_W-1:0]    r_budget;
    logic [CNT_W-1:0]   r_retired;
    logic               r_acc;
    logic               r_rej;
    t_req               r_item;
    t_rsp               r_rsp;

    logic [LIM_W-1:0]   lim;
    logic [LIM_W-1:0]   occ_ext;
    logic [LIM_W-1:0]   free_cnt;
    logic               has_free;
    logic               head_xfer;
    logic [WORDS_W-1:0] head_words;
    logic               budget_short;
    logic               walk_stop;
    logic               do_issue;
    logic               do_retire;
    logic               do_partial;
    logic               do_count;
    logic [IDX_W-1:0]   head_inc;
    logic [IDX_W-1:0]   tail_inc;
    logic [WORDS_W-1:0] new_words;

    // Slot limit is the smaller of the programmed limit and the queue depth.
    assign lim = (LIM_W'(i_cfg.max_in_flight) > LIM_W'(QUEUE_DEPTH)) ?
                 LIM_W'(QUEUE_DEPTH) : LIM_W'(i_cfg.max_in_flight);
    assign occ_ext  = LIM_W'(r_occ);
    assign has_free = (occ_ext < lim);
    assign free_cnt = has_free ? (lim - occ_ext) : '0;

    assign head_xfer    = (r_occ != '0) && (r_phase[r_head] == PH_XFER);
    assign head_words   = r_words[r_head];
    assign budget_short = (WORDS_W'(r_budget) < head_words);
    assign walk_stop    = !head_xfer || (r_budget == '0) || budget_short;

    assign do_issue   = i_cmd.exec && r_item.req_type && has_free;
    assign do_retire  = i_cmd.walk && !walk_stop;
    assign do_partial = i_cmd.walk && walk_stop && head_xfer && (r_budget != '0);
    assign do_count   = i_cmd.walk && walk_stop;

    assign head_inc = (r_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    assign new_words = WORDS_W'(r_item.payload_words) + WORDS_W'({i_cfg.header_words, 1'b0});

    assign o_sts.item_is_req = r_item.req_type;
    assign o_sts.walk_stop   = walk_stop;
    assign o_rsp             = r_rsp;

    // Slot phases and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_phase[i] <= PH_EMPTY;
            end
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            if (do_issue) begin
                r_phase[r_tail] <= (i_cfg.total_latency != '0) ? PH_WAIT : PH_XFER;
                r_tail          <= tail_inc;
                r_occ           <= r_occ + 1'b1;
            end
            if (do_retire) begin
                r_phase[r_head] <= PH_EMPTY;
                r_head          <= head_inc;
                r_occ           <= r_occ - 1'b1;
            end
            if (do_count) begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if ((r_phase[i] == PH_WAIT) && (r_lat[i] <= LAT_W'(1))) begin
                        r_phase[i] <= PH_XFER;
                    end
                end
            end
        end
    end

    // Per-slot latency and remaining word counts.
    always_ff @(posedge i_clk) begin
        if (do_issue) begin
            r_lat[r_tail]   <= i_cfg.total_latency;
            r_words[r_tail] <= new_words;
        end
        if (do_partial) begin
            r_words[r_head] <= head_words - WORDS_W'(r_budget);
        end
        if (do_count) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if ((r_phase[i] == PH_WAIT) && (r_lat[i] > LAT_W'(1))) begin
                    r_lat[i] <= r_lat[i] - 1'b1;
                end
            end
        end
    end

    // Item, walk budget and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_req;
        end
        if (i_cmd.exec) begin
            r_acc     <= do_issue;
            r_rej     <= r_item.req_type && !has_free;
            r_budget  <= i_cfg.bandwidth_words;
            r_retired <= '0;
        end
        if (do_retire) begin
            r_budget  <= r_budget - BW_W'(head_words);
            r_retired <= r_retired + 1'b1;
        end
        if (i_cmd.emit) begin
            r_rsp.accepted        <= r_acc;
            r_rsp.rejected_full   <= r_rej;
            r_rsp.completed_count <= OUT_CNT_W'(r_retired);
            r_rsp.free_slots      <= OUT_CNT_W'(free_cnt);
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy exceeds queue depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_head == r_tail))
        else $error("empty queue with head and tail apart");

    a_retire_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_retire |=> (r_occ == $past(r_occ) - 1'b1))
        else $error("retire did not lower occupancy");

    a_issue_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_issue |=> (r_occ == $past(r_occ) + 1'b1) && r_acc)
        else $error("issued request not counted");

endmodule

FILE: src/memory_request_latency_bandwidth_queue.sv
// A new request is captured, executed, and its result registered in the finish
// state. A tick also walks the queue: one retired head slot per walk cycle,
// plus the walk cycle that ends the walk and counts every waiting slot down.
// The next request is accepted in the cycle after a result is registered, so
// requests are taken one at a time; the result waits while the output stalls.
// Synchronous active-low reset empties every slot and loads default config.
module memory_request_latency_bandwidth_queue
    import mrlbq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  t_req        i_req,

    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output t_rsp        o_rsp,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Register indexes come from the package; each register sits at byte
    // address 4 * index.
    t_cfg    r_cfg;
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    cfg_wr;
    logic [1:0] reg_idx;

    // The APB port never inserts wait states. Writes are only expected while
    // the queue is idle, so the datapath sees the new value on the next item.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_latency   <= LAT_W'(100);
            r_cfg.header_words    <= HDR_W'(1);
            r_cfg.bandwidth_words <= BW_W'(4);
            r_cfg.max_in_flight   <= MIF_W'(16);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_TOTAL_LATENCY:   r_cfg.total_latency   <= pwdata[LAT_W-1:0];
                REG_HEADER_WORDS:    r_cfg.header_words    <= pwdata[HDR_W-1:0];
                REG_BANDWIDTH_WORDS: r_cfg.bandwidth_words <= pwdata[BW_W-1:0];
                REG_MAX_IN_FLIGHT:   r_cfg.max_in_flight   <= pwdata[MIF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back is combinational from the configuration registers.
    always_comb begin
        unique case (reg_idx)
            REG_TOTAL_LATENCY:   prdata = 32'(r_cfg.total_latency);
            REG_HEADER_WORDS:    prdata = 32'(r_cfg.header_words);
            REG_BANDWIDTH_WORDS: prdata = 32'(r_cfg.bandwidth_words);
            REG_MAX_IN_FLIGHT:   prdata = 32'(r_cfg.max_in_flight);
            default:             prdata = '0;
        endcase
    end

    // The controller sequences each request: capture, execute (issue or
    // reject a request, or start a tick), walk the head of the queue for a
    // tick, and finally register the result once the output side can take it.
    mrlbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the slot queue. During a tick it spends the word
    // budget on the head slot each cycle, retiring it when its transfer
    // completes, and on the last walk cycle counts down every waiting slot.
    mrlbq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_rsp   (o_rsp)
    );

endmodule
